// ===== rtl/sfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants for the sonar frame parser
// Holds the parser state encoding, the frame start byte and the result item.
// ----------------------------------------------------------------------------
package sfp_pkg;

    // Frame start character '$'
    localparam logic [7:0] START_BYTE = 8'h24;

    // Position within a seven-byte frame; the unused code falls back to hunting
    typedef enum logic [2:0] {
        ST_HUNT    = 3'd0,
        ST_NAME1   = 3'd1,
        ST_NAME2   = 3'd2,
        ST_PORT    = 3'd3,
        ST_DIST_LO = 3'd4,
        ST_DIST_HI = 3'd5,
        ST_CHECK   = 3'd6
    } sfp_state_t;

    // One decoded distance frame
    typedef struct packed {
        logic [7:0]  name_first;
        logic [7:0]  name_second;
        logic [7:0]  port_number;
        logic [15:0] distance;
    } sfp_result_t;

endpackage : sfp_pkg
`default_nettype wire

// ===== rtl/sonar_frame_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sonar_frame_parser_top: serial distance-frame parser
// Recognizes seven-byte '$' frames with an XOR checksum and emits the
// name, port and distance of every frame whose checksum matches.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per item (s_rx_byte), valid/ready.
//   m_ channel: one item per good frame (name, port, distance), valid/ready.
//   Bytes other than '$' while hunting are dropped. A '$' inside a frame is
//   an ordinary data byte. Frames with a bad checksum give no item; the
//   parser returns to hunting after every checksum byte either way.
//   Output: the result item shows on m_ in the cycle after the checksum
//   byte is accepted.
//   Throughput: one byte per cycle unless stalled; the parser updates its
//   state in the accept cycle, and the single output register takes it.
//   Stall: s_ready stays high while the output register is empty or being
//   emptied in the same cycle; with a result held and m_ready low, s_ready
//   drops and the item waits unchanged.
//   Reset: synchronous, active low; parser returns to hunting with a
//   cleared checksum and the output register empties.
// ----------------------------------------------------------------------------
module sonar_frame_parser_top
    import sfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_name_first,
    output logic [7:0]       m_name_second,
    output logic [7:0]       m_port_number,
    output logic [15:0]      m_distance
);

    logic        byte_take;
    logic        frame_hit;
    sfp_result_t frame;
    logic        out_valid_reg, out_valid_next;
    sfp_result_t out_reg, out_next;

    // Accept a byte whenever the output slot is free or draining
    assign s_ready   = !out_valid_reg || m_ready;
    assign byte_take = s_valid && s_ready;

    sfp_frame_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_take (byte_take),
        .rx_byte   (s_rx_byte),
        .frame_hit (frame_hit),
        .frame     (frame)
    );

    // Load a good frame, drop the slot once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (frame_hit) begin
            out_valid_next = 1'b1;
            out_next       = frame;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_name_first  = out_reg.name_first;
    assign m_name_second = out_reg.name_second;
    assign m_port_number = out_reg.port_number;
    assign m_distance    = out_reg.distance;

endmodule : sonar_frame_parser_top
`default_nettype wire

// ===== rtl/sfp_frame_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_frame_fsm: byte-level frame recognizer
// Tracks the frame position, the running XOR and the held fields, and flags
// a good frame in the same cycle that its checksum byte is accepted.
// ----------------------------------------------------------------------------
module sfp_frame_fsm
    import sfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        byte_take,
    input  wire logic [7:0]  rx_byte,
    output logic             frame_hit,
    output sfp_result_t      frame
);

    sfp_state_t  state_reg, state_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  name1_reg, name1_next;
    logic [7:0]  name2_reg, name2_next;
    logic [7:0]  port_reg, port_next;
    logic [15:0] dist_reg, dist_next;

    // Next state and running checksum
    always_comb begin
        state_next = state_reg;
        xor_next   = xor_reg;
        if (byte_take) begin
            case (state_reg)
                ST_NAME1: begin
                    state_next = ST_NAME2;
                    xor_next   = xor_reg ^ rx_byte;
                end
                ST_NAME2: begin
                    state_next = ST_PORT;
                    xor_next   = xor_reg ^ rx_byte;
                end
                ST_PORT: begin
                    state_next = ST_DIST_LO;
                    xor_next   = xor_reg ^ rx_byte;
                end
                ST_DIST_LO: begin
                    state_next = ST_DIST_HI;
                    xor_next   = xor_reg ^ rx_byte;
                end
                ST_DIST_HI: begin
                    state_next = ST_CHECK;
                    xor_next   = xor_reg ^ rx_byte;
                end
                ST_CHECK: begin
                    state_next = ST_HUNT;
                    xor_next   = '0;
                end
                default: begin
                    // Hunt: drop anything but the start byte
                    if (rx_byte == START_BYTE) begin
                        state_next = ST_NAME1;
                        xor_next   = xor_reg ^ START_BYTE;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            endcase
        end
    end

    // Field capture and frame flag
    always_comb begin
        name1_next = name1_reg;
        name2_next = name2_reg;
        port_next  = port_reg;
        dist_next  = dist_reg;
        frame_hit  = 1'b0;
        if (byte_take) begin
            case (state_reg)
                ST_NAME1:   name1_next = rx_byte;
                ST_NAME2:   name2_next = rx_byte;
                ST_PORT:    port_next  = rx_byte;
                ST_DIST_LO: dist_next  = {8'h00, rx_byte};
                ST_DIST_HI: dist_next  = {rx_byte, dist_reg[7:0]};
                ST_CHECK:   frame_hit  = (xor_reg == rx_byte);
                default:    ;
            endcase
        end
    end

    assign frame.name_first  = name1_reg;
    assign frame.name_second = name2_reg;
    assign frame.port_number = port_reg;
    assign frame.distance    = dist_reg;

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            xor_reg   <= '0;
            name1_reg <= '0;
            name2_reg <= '0;
            port_reg  <= '0;
            dist_reg  <= '0;
        end else begin
            state_reg <= state_next;
            xor_reg   <= xor_next;
            name1_reg <= name1_next;
            name2_reg <= name2_next;
            port_reg  <= port_next;
            dist_reg  <= dist_next;
        end
    end

endmodule : sfp_frame_fsm
`default_nettype wire

// ===== rtl/sfp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_checker: port-level checks for the sonar frame parser
// Watches the top-level ports and flags stalls, spurious items and reset
// behavior that break the parser's contract.
// ----------------------------------------------------------------------------
module sfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_name_first,
    input wire logic [7:0]  m_name_second,
    input wire logic [7:0]  m_port_number,
    input wire logic [15:0] m_distance
);

    // Hold a stalled result item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_name_first)
            && $stable(m_name_second) && $stable(m_port_number)
            && $stable(m_distance)))
        else $error("sfp: stalled result item changed");

    // Output empties on reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("sfp: result valid after reset");

    // Never refuse a byte while the output slot is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("sfp: input stalled with empty output");

    // A new result item needs an accepted byte in the cycle before
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("sfp: result item without input byte");

    // Drop a result item after its handshake unless a new one was loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (!m_valid || $past(s_valid && s_ready)))
        else $error("sfp: repeated result item");

endmodule : sfp_checker

bind sonar_frame_parser_top sfp_checker u_sfp_checker (.*);
`default_nettype wire

// ===== bench/sonar_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_frame_parser_top_tb: self-checking bench for the sonar frame parser
// Feeds byte streams of '$' frames, noise and cut-off frames through the
// s_ channel. A behavioral parser runs alongside and queues the decoded
// frames that should appear on the m_ channel, which are compared field by
// field. Both sides idle at random, and the result side holds off once for
// a long stretch so the parser backs up and stalls its input.
// ----------------------------------------------------------------------------
module sonar_frame_parser_top_tb;
    import sfp_pkg::*;

    localparam int N_WORK_BYTES   = 1150;
    localparam int N_DIRECTED     = 23;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // How a directed row gets its expected frame
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_GIVEN
    } exp_kind_t;

    typedef struct {
        logic [7:0]  rx_byte;
        exp_kind_t   kind;
        sfp_result_t frame;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_name_first;
    logic [7:0]  m_name_second;
    logic [7:0]  m_port_number;
    logic [15:0] m_distance;

    // Behavioral parser state
    sfp_state_t  frame_pos    = ST_HUNT;
    logic [7:0]  running_sum  = 8'h00;
    sfp_result_t held_frame   = '0;
    sfp_result_t frames_q[$];

    int err_count    = 0;
    int work_bytes   = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;

    // Directed rows: noise, all-zero frame, all-ones frame, bad frame with '$' inside
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, EXP_NONE,  '0},
        '{8'hFF, EXP_NONE,  '0},
        '{8'h24, EXP_MODEL, '0},
        '{8'h00, EXP_MODEL, '0},
        '{8'h00, EXP_MODEL, '0},
        '{8'h00, EXP_MODEL, '0},
        '{8'h00, EXP_MODEL, '0},
        '{8'h00, EXP_MODEL, '0},
        '{8'h24, EXP_GIVEN, '{8'h00, 8'h00, 8'h00, 16'h0000}},
        '{8'h24, EXP_MODEL, '0},
        '{8'hFF, EXP_MODEL, '0},
        '{8'hFF, EXP_MODEL, '0},
        '{8'hFF, EXP_MODEL, '0},
        '{8'hFF, EXP_MODEL, '0},
        '{8'hFF, EXP_MODEL, '0},
        '{8'hDB, EXP_GIVEN, '{8'hFF, 8'hFF, 8'hFF, 16'hFFFF}},
        '{8'h24, EXP_MODEL, '0},
        '{8'h53, EXP_MODEL, '0},
        '{8'h4F, EXP_MODEL, '0},
        '{8'h24, EXP_MODEL, '0},
        '{8'h34, EXP_MODEL, '0},
        '{8'h12, EXP_MODEL, '0},
        '{8'h3B, EXP_NONE,  '0}
    };

    sonar_frame_parser_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_name_first  (m_name_first),
        .m_name_second (m_name_second),
        .m_port_number (m_port_number),
        .m_distance    (m_distance)
    );

    always #6 aclk = ~aclk;

    // Offer one byte in bursts, wait for the handshake, then advance the parser model
    task automatic send_byte(input logic [7:0] rx, input exp_kind_t kind,
                             input sfp_result_t given);
        int  gap;
        bit  frame_ok;
        bit  dropped;
        frame_ok = 1'b0;
        dropped  = 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);

        case (frame_pos)
            ST_NAME1: begin
                held_frame.name_first = rx;
                running_sum ^= rx;
                frame_pos = ST_NAME2;
            end
            ST_NAME2: begin
                held_frame.name_second = rx;
                running_sum ^= rx;
                frame_pos = ST_PORT;
            end
            ST_PORT: begin
                held_frame.port_number = rx;
                running_sum ^= rx;
                frame_pos = ST_DIST_LO;
            end
            ST_DIST_LO: begin
                held_frame.distance = {8'h00, rx};
                running_sum ^= rx;
                frame_pos = ST_DIST_HI;
            end
            ST_DIST_HI: begin
                held_frame.distance[15:8] = rx;
                running_sum ^= rx;
                frame_pos = ST_CHECK;
            end
            ST_CHECK: begin
                frame_ok    = (running_sum == rx);
                running_sum = 8'h00;
                frame_pos   = ST_HUNT;
            end
            default: begin
                if (rx == START_BYTE) begin
                    running_sum ^= START_BYTE;
                    frame_pos = ST_NAME1;
                end else begin
                    frame_pos = ST_HUNT;
                    dropped   = 1'b1;
                end
            end
        endcase
        if (!dropped) work_bytes++;

        case (kind)
            EXP_MODEL: if (frame_ok) frames_q.push_back(held_frame);
            EXP_GIVEN: frames_q.push_back(given);
            default: ;
        endcase
    endtask

    // Byte stream: directed rows, then mostly well-formed frames plus noise
    initial begin : byte_source
        logic [7:0] fb [7];
        logic [7:0] sum;
        int         frame_len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(directed_rows[i].rx_byte, directed_rows[i].kind, directed_rows[i].frame);
        end

        work_bytes = 0;
        while (work_bytes < N_WORK_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise between frames, may itself contain a start byte
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), EXP_MODEL, '0);
            end else begin
                fb[0] = START_BYTE;
                for (int k = 1; k <= 5; k++) begin
                    fb[k] = ($urandom_range(0, 19) == 0) ? START_BYTE : 8'($urandom);
                end
                if ($urandom_range(0, 9) == 0) begin
                    {fb[5], fb[4]} = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                sum = 8'h00;
                for (int k = 0; k <= 5; k++) sum ^= fb[k];
                fb[6] = ($urandom_range(0, 4) == 0) ? sum ^ 8'($urandom_range(1, 255)) : sum;
                // cut some frames short so the next bytes land mid-frame
                frame_len = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 6) : 7;
                for (int k = 0; k < frame_len; k++) send_byte(fb[k], EXP_MODEL, '0);
            end
        end
        s_valid <= 1'b0;

        while (frames_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && frames_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Check result items and drive m_ready on a changing stall pattern
    initial begin : frame_sink
        sfp_result_t exp_frame;
        int          mode_left;
        int          rx_mode;
        int          phase;
        bit          held_once;
        bit          rdy;
        mode_left = 0;
        rx_mode   = 0;
        phase     = 0;
        held_once = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_seen++;
                if (frames_q.size() == 0) begin
                    $error("unexpected result item: name %h %h port %h distance %h",
                           m_name_first, m_name_second, m_port_number, m_distance);
                    err_count++;
                end else begin
                    exp_frame = frames_q.pop_front();
                    if (m_name_first !== exp_frame.name_first) begin
                        $error("name_first: expected %h, got %h",
                               exp_frame.name_first, m_name_first);
                        err_count++;
                    end
                    if (m_name_second !== exp_frame.name_second) begin
                        $error("name_second: expected %h, got %h",
                               exp_frame.name_second, m_name_second);
                        err_count++;
                    end
                    if (m_port_number !== exp_frame.port_number) begin
                        $error("port_number: expected %h, got %h",
                               exp_frame.port_number, m_port_number);
                        err_count++;
                    end
                    if (m_distance !== exp_frame.distance) begin
                        $error("distance: expected %h, got %h",
                               exp_frame.distance, m_distance);
                        err_count++;
                    end
                end
            end

            if (!held_once && results_seen >= 30) begin
                // hold off long enough for the parser to back up into s_ready
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                phase++;
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 4) == 0);
                    default: rdy = (phase % 3 == 0);
                endcase
                m_ready <= rdy;
            end
        end
    end

    // End the run when no item moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sonar_frame_parser_top.f =====
rtl/sfp_pkg.sv
rtl/sfp_frame_fsm.sv
rtl/sonar_frame_parser_top.sv
rtl/sfp_checker.sv
bench/sonar_frame_parser_top_tb.sv
